[rtl/csu_pkg.sv]
// Shared types, constants and command codes for the cosine similarity unit.
// No dependencies.
`default_nettype none
package csu_pkg;

   localparam int MAX_DIM_DEF = 1024;
   // bits of the score magnitude that the search resolves
   localparam int K_BITS      = 15;
   localparam int BIT_W       = $clog2(K_BITS);

   typedef struct packed {
      logic signed [15:0] elem_a;
      logic signed [15:0] elem_b;
      logic               last_elem;
   } req_word_type;

   typedef struct packed {
      logic [15:0] similarity;
      logic        zero_norm;
      logic        too_long;
   } rsp_word_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_LOAD_P,
      OP_MUL,
      OP_SAVE_P,
      OP_SAVE_D,
      OP_SQ,
      OP_LOAD_K,
      OP_CMP,
      OP_FIN
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [BIT_W-1:0] bit_idx;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic zero_norm;
      logic rsp_free;
   } status_type;

endpackage
`default_nettype wire

[rtl/csu_ctrl.sv]
// Sequencer for the cosine similarity unit: element intake, norm product,
// dot square and the bitwise score search. Depends on csu_pkg.
`default_nettype none
module csu_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   input  wire                 req_last,
   input  csu_pkg::status_type status,
   output csu_pkg::cmd_type    cmd,
   output logic                req_stall
);
   import csu_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_CHECK = 7'b0000010,
      S_MULP  = 7'b0000100,
      S_MULD  = 7'b0001000,
      S_SQ    = 7'b0010000,
      S_MULK  = 7'b0100000,
      S_FIN   = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   logic [BIT_W-1:0] bit_ff, bit_in;
   logic             load_k_ff, load_k_in;

   // next state and command
   always_comb begin
      state_in  = state_ff;
      bit_in    = bit_ff;
      load_k_in = 1'b0;
      cmd.op    = OP_NONE;
      cmd.bit_idx = bit_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.op = OP_ACCEPT;
            if (req_valid && req_last) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (status.zero_norm) begin
               state_in = S_FIN;
            end else begin
               cmd.op   = OP_LOAD_P;
               state_in = S_MULP;
            end
         end
         S_MULP: begin
            if (status.mul_done) begin
               cmd.op   = OP_SAVE_P;
               state_in = S_MULD;
            end else begin
               cmd.op = OP_MUL;
            end
         end
         S_MULD: begin
            if (status.mul_done) begin
               cmd.op   = OP_SAVE_D;
               bit_in   = BIT_W'(K_BITS - 1);
               state_in = S_SQ;
            end else begin
               cmd.op = OP_MUL;
            end
         end
         S_SQ: begin
            // form the trial value, then load the multiplier next cycle
            cmd.op    = OP_SQ;
            load_k_in = 1'b1;
            state_in  = S_MULK;
         end
         S_MULK: begin
            if (load_k_ff) begin
               cmd.op = OP_LOAD_K;
            end else if (status.mul_done) begin
               cmd.op = OP_CMP;
               if (bit_ff == '0) begin
                  state_in = S_FIN;
               end else begin
                  bit_in   = bit_ff - BIT_W'(1);
                  state_in = S_SQ;
               end
            end else begin
               cmd.op = OP_MUL;
            end
         end
         S_FIN: begin
            if (status.rsp_free) begin
               cmd.op   = OP_FIN;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         bit_ff    <= '0;
         load_k_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         bit_ff    <= bit_in;
         load_k_ff <= load_k_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule
`default_nettype wire

[rtl/csu_datapath.sv]
// Accumulators, shift-add multiplier, search registers and output word
// register of the cosine similarity unit. Depends on csu_pkg.
`default_nettype none
module csu_datapath #(
   parameter int MAX_DIM = csu_pkg::MAX_DIM_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  csu_pkg::cmd_type      cmd,
   input  wire                   req_valid,
   input  csu_pkg::req_word_type req_word,
   output csu_pkg::status_type   status,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output csu_pkg::rsp_word_type rsp_word
);
   import csu_pkg::*;

   localparam int CNT_W  = $clog2(MAX_DIM + 1);
   localparam int NORM_W = 30 + CNT_W;
   localparam int DOT_W  = NORM_W + 1;
   localparam int P_W    = 2 * NORM_W;
   localparam int ACC_W  = P_W + 2 * K_BITS;

   logic signed [DOT_W-1:0] dot_ff;
   logic [NORM_W-1:0]       na_ff, nb_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic                    ovf_ff;
   logic [ACC_W-1:0]        mcand_ff, macc_ff, dsq_ff;
   logic [NORM_W-1:0]       mplier_ff;
   logic [P_W-1:0]          p_ff;
   logic [K_BITS-1:0]       k_ff, trial_ff;
   logic                    rsp_valid_ff;
   rsp_word_type            rsp_word_ff;

   logic signed [31:0]      prod_ab, prod_aa, prod_bb;
   logic signed [DOT_W-1:0] dot_neg;
   logic [NORM_W-1:0]       dmag;
   logic                    neg;
   logic [2*K_BITS-1:0]     trial_sq;
   logic                    pass;
   logic                    rsp_free;
   logic [15:0]             score;

   assign prod_ab  = req_word.elem_a * req_word.elem_b;
   assign prod_aa  = req_word.elem_a * req_word.elem_a;
   assign prod_bb  = req_word.elem_b * req_word.elem_b;
   assign neg      = dot_ff[DOT_W-1];
   assign dot_neg  = -dot_ff;
   assign dmag     = neg ? dot_neg[NORM_W-1:0] : dot_ff[NORM_W-1:0];
   assign trial_sq = trial_ff * trial_ff;
   // negative dot needs strict inequality, positive allows equality
   assign pass     = neg ? (macc_ff < dsq_ff) : (macc_ff <= dsq_ff);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign score    = neg ? (16'd32767 - {1'b0, k_ff}) : {1'b1, k_ff};

   // accumulators and length tracking
   always_ff @(posedge clock) begin
      if (reset || cmd.op == OP_FIN) begin
         dot_ff <= '0;
         na_ff  <= '0;
         nb_ff  <= '0;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (cmd.op == OP_ACCEPT && req_valid) begin
         if (cnt_ff < CNT_W'(MAX_DIM)) begin
            dot_ff <= dot_ff + DOT_W'(prod_ab);
            na_ff  <= na_ff + NORM_W'(unsigned'(prod_aa));
            nb_ff  <= nb_ff + NORM_W'(unsigned'(prod_bb));
            cnt_ff <= cnt_ff + CNT_W'(1);
         end else begin
            ovf_ff <= 1'b1;
         end
      end
   end

   // shift-add multiplier and search registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD_P: begin
            mcand_ff  <= ACC_W'(na_ff);
            mplier_ff <= nb_ff;
            macc_ff   <= '0;
         end
         OP_MUL: begin
            if (mplier_ff[0]) macc_ff <= macc_ff + mcand_ff;
            mcand_ff  <= mcand_ff << 1;
            mplier_ff <= mplier_ff >> 1;
         end
         OP_SAVE_P: begin
            p_ff      <= macc_ff[P_W-1:0];
            mcand_ff  <= ACC_W'(dmag);
            mplier_ff <= dmag;
            macc_ff   <= '0;
         end
         OP_SAVE_D: begin
            dsq_ff <= {macc_ff[P_W-1:0], (2*K_BITS)'(0)};
            k_ff   <= '0;
         end
         OP_SQ: begin
            trial_ff <= k_ff | (K_BITS'(1) << cmd.bit_idx);
         end
         OP_LOAD_K: begin
            mcand_ff  <= ACC_W'(p_ff);
            mplier_ff <= NORM_W'(trial_sq);
            macc_ff   <= '0;
         end
         OP_CMP: begin
            if (pass) k_ff <= trial_ff;
         end
         default: ;
      endcase
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_FIN) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.op == OP_FIN) begin
         rsp_word_ff.zero_norm  <= status.zero_norm;
         rsp_word_ff.similarity <= status.zero_norm ? 16'd0 : score;
         rsp_word_ff.too_long   <= ovf_ff;
      end
   end

   assign status.mul_done  = (mplier_ff == '0);
   assign status.zero_norm = (na_ff == '0) || (nb_ff == '0);
   assign status.rsp_free  = rsp_free;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_word         = rsp_word_ff;

endmodule
`default_nettype wire

[rtl/cosine_similarity_unit.sv]
// Top level of the cosine similarity unit: controller plus datapath.
// Depends on csu_pkg, csu_ctrl and csu_datapath.
//
// Usage: element pairs (elem_a, elem_b, Q1.15) enter on the req_ channel,
// one word per cycle while req_stall is low. Dot product and both squared
// norms accumulate as words arrive. The word with last_elem set starts
// the score computation; req_stall stays high until it finishes.
// Pairs beyond MAX_DIM are dropped and flag too_long in the result.
// After the last word the sequencer checks the norms, multiplies norm_a
// by norm_b, squares |dot| and runs 15 search steps, each a trial square
// times the norm product compared with the dot square; zero-norm results
// skip to the output. The shift-add multiplier is serial, one bit per cycle.
// Throughput: one element word per cycle within a vector.
// The result word sits in an output register; a stalled rsp_ channel holds
// it, and a following vector may stream in meanwhile, its result waiting
// until the register is taken.
// Reset (synchronous) clears accumulators, sequencer and rsp_valid.
`default_nettype none
module cosine_similarity_unit #(
   parameter int MAX_DIM = csu_pkg::MAX_DIM_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  csu_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output csu_pkg::rsp_word_type rsp_word
);
   import csu_pkg::*;

   cmd_type    cmd;
   status_type status;

   csu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_word.last_elem),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   csu_datapath #(.MAX_DIM(MAX_DIM)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_valid (req_valid),
      .req_word  (req_word),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule
`default_nettype wire

[rtl/csu_checker.sv]
// Port-level checks for the cosine similarity unit, bound to the top level.
// Depends on csu_pkg and cosine_similarity_unit.
`default_nettype none
module csu_checker (
   input wire                   clock,
   input wire                   reset,
   input wire                   req_valid,
   input wire                   req_stall,
   input csu_pkg::req_word_type req_word,
   input wire                   rsp_valid,
   input wire                   rsp_stall,
   input csu_pkg::rsp_word_type rsp_word
);
   import csu_pkg::*;

   // held result word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result word changed");

   // a last word starts the computation, intake closes
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_word.last_elem |=> req_stall)
      else $error("intake open after last word");

   // zero norm forces a zero score
   a_zero_score: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.zero_norm |-> rsp_word.similarity == 16'd0)
      else $error("nonzero score with zero norm");

   // reset leaves the block idle and empty
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind cosine_similarity_unit csu_checker u_csu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
`default_nettype wire

[sim/tb_top.sv]
// Testbench for cosine_similarity_unit: drives element words, predicts scores with an
// exact integer bisection, and checks every result word.
// Depends on csu_pkg and the cosine_similarity_unit RTL.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import csu_pkg::*;

   localparam int MAX_DIM = 1024;
   localparam int WATCH_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   cosine_similarity_unit #(.MAX_DIM(MAX_DIM)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   always #4 clock = ~clock;

   // predictor state
   logic signed [63:0] dot_sum;
   logic [63:0] norm_a_sum, norm_b_sum;
   int pair_count;
   bit dropped;
   rsp_word_type score_queue[$];
   int errors = 0;
   int idle_cycles = 0;
   bit hold_rsp = 1'b0;
   bit rx_gaps = 1'b1;

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      errors++;
   endtask

   // largest t in [-32768,32767] with t*sqrt(P) <= 32768*dot
   function automatic int cosine_score(input logic signed [63:0] d,
                                       input logic [63:0] na, input logic [63:0] nb);
      logic [255:0] prod, dsq, lhs, mag;
      int lo, hi, mid, tm;
      bit neg, ok;
      neg = d < 0;
      mag = neg ? 256'(-d) : 256'(d);
      dsq = (mag << 15) * (mag << 15);
      prod = 256'(na) * 256'(nb);
      lo = -32768; hi = 32767;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         if (mid <= 0 && !neg) ok = 1;
         else if (mid > 0 && neg) ok = 0;
         else begin
            tm = mid < 0 ? -mid : mid;
            lhs = prod * 256'(tm) * 256'(tm);
            ok = (mid > 0) ? (lhs <= dsq) : (lhs >= dsq);
         end
         if (ok) lo = mid;
         else hi = mid - 1;
      end
      return lo + 32768;
   endfunction

   function automatic void predict(input req_word_type w);
      rsp_word_type r;
      if (pair_count < MAX_DIM) begin
         dot_sum += 64'(w.elem_a) * 64'(w.elem_b);
         norm_a_sum += 64'(w.elem_a * w.elem_a);
         norm_b_sum += 64'(w.elem_b * w.elem_b);
         pair_count++;
      end else dropped = 1;
      if (!w.last_elem) return;
      r = '0;
      if (norm_a_sum == 0 || norm_b_sum == 0) r.zero_norm = 1;
      else r.similarity = 16'(cosine_score(dot_sum, norm_a_sum, norm_b_sum) > 65535 ?
                              65535 : cosine_score(dot_sum, norm_a_sum, norm_b_sum));
      r.too_long = dropped;
      score_queue.push_back(r);
      dot_sum = 0; norm_a_sum = 0; norm_b_sum = 0; pair_count = 0; dropped = 0;
   endfunction

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // sends one word; predicts at acceptance; valid stays up for a following word
   task automatic send_word(input logic signed [15:0] a, input logic signed [15:0] b,
                            input bit last, input bit gaps);
      int g;
      g = gaps ? gap_len() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= '{elem_a: a, elem_b: b, last_elem: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict('{elem_a: a, elem_b: b, last_elem: last});
   endtask

   task automatic send_vector(input int len, input int kind, input bit gaps);
      logic signed [15:0] a, b;
      for (int i = 0; i < len; i++) begin
         case (kind)
            0: begin a = 16'($urandom); b = 16'($urandom); end
            1: begin a = 16'($urandom); b = a; end
            2: begin a = 16'($urandom); b = -a; end
            3: begin a = 16'($urandom_range(0, 3)) - 16'sd1; b = 16'($urandom); end
            default: begin a = 16'($urandom) >>> $urandom_range(0, 15);
               b = 16'($urandom) >>> $urandom_range(0, 15); end
         endcase
         send_word(a, b, i == len - 1, gaps);
      end
   endtask

   // sender goes quiet until every expected result is out
   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (score_queue.size() != 0) @(posedge clock);
   endtask

   // result checker and receiver stall
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (score_queue.size() == 0) report("unexpected word", 1, 0);
            else begin
               if (rsp_word.similarity !== score_queue[0].similarity)
                  report("similarity", rsp_word.similarity, score_queue[0].similarity);
               if (rsp_word.zero_norm !== score_queue[0].zero_norm)
                  report("zero_norm", rsp_word.zero_norm, score_queue[0].zero_norm);
               if (rsp_word.too_long !== score_queue[0].too_long)
                  report("too_long", rsp_word.too_long, score_queue[0].too_long);
               void'(score_queue.pop_front());
            end
         end
         rsp_stall <= hold_rsp || (rx_gaps && $urandom_range(0, 99) < 30);
      end
   end

   // watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   task automatic test_extremes();
      send_word(16'sh7FFF, 16'sh7FFF, 1, 0);
      send_word(16'sh8000, 16'sh8000, 1, 0);
      send_word(16'sh8000, 16'sh7FFF, 1, 0);
      send_word(16'sh7FFF, 16'sh8000, 0, 0);
      send_word(16'sh8000, 16'sh7FFF, 1, 0);
      send_word(16'sh0001, 16'shFFFF, 1, 0);
      send_word(16'sh1234, 16'sh0000, 1, 0);
      send_word(16'sh0000, 16'sh0000, 1, 0);
      send_word(16'sh0000, 16'sh5555, 1, 0);
      send_word(16'sh5555, 16'shAAAA, 0, 0);
      send_word(16'sh2AAA, 16'shD555, 1, 0);
      send_word(16'sh0003, 16'sh0004, 0, 0);
      send_word(16'sh0004, 16'shFFFD, 1, 0);
      send_vector(3, 1, 0);
      send_vector(3, 2, 0);
      wait_drain();
   endtask

   // one run past MAX_DIM, last pair itself dropped
   task automatic test_too_long();
      send_vector(MAX_DIM + 2, 1, 1);
      wait_drain();
   endtask

   task automatic test_backpressure();
      int hold;
      hold_rsp = 1;
      fork
         begin hold = 0; while (hold < 3000) begin @(posedge clock); hold++; end
            hold_rsp = 0; end
         for (int v = 0; v < 6; v++) send_vector($urandom_range(1, 8), 0, 0);
      join
      wait_drain();
   endtask

   task automatic test_random();
      int sent, len, kind;
      sent = 0;
      while (sent < 780) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
         kind = $urandom_range(0, 4);
         rx_gaps = $urandom_range(0, 4) != 0;
         send_vector(len, kind, $urandom_range(0, 3) != 0);
         sent += len;
      end
      rx_gaps = 1;
      wait_drain();
   endtask

   initial begin
      dot_sum = 0; norm_a_sum = 0; norm_b_sum = 0; pair_count = 0; dropped = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_backpressure();
      test_random();
      test_too_long();
      repeat (700) @(posedge clock);
      if (errors == 0 && score_queue.size() == 0) $display("tb_top passed");
      else $display("tb_top failed");
      $finish;
   end
endmodule
`default_nettype wire
